// File: rtl/wft_pkg.sv
`timescale 1ns / 1ps

package wft_pkg;

    // action codes carried in the input tuser
    typedef enum logic [1:0] {
        ACT_TEXT = 2'd0,
        ACT_SORT = 2'd1,
        ACT_READ = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_TAB   = 8'h09;
    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_UP_A  = 8'h41;
    localparam logic [7:0]  CH_UP_Z  = 8'h5A;
    localparam logic [7:0]  CH_LO_A  = 8'h61;
    localparam logic [7:0]  CH_LO_Z  = 8'h7A;
    localparam logic [7:0]  CASE_OFS = 8'h20;
    localparam logic [23:0] FREQ_MAX = 24'hFFFFFF;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FL_E,
        ST_FL_L,
        ST_FL_CW,
        ST_FL_C,
        ST_CP_W,
        ST_CP,
        ST_FL_DONE,
        ST_INIT,
        ST_SI,
        ST_SI_RD,
        ST_SI_GET,
        ST_SJ,
        ST_SJ_RD,
        ST_SJ_GET,
        ST_CMP_RD,
        ST_CMP_F,
        ST_CMP_CW,
        ST_CMP_C,
        ST_RQ_RD,
        ST_RQ_GET,
        ST_RQ_W,
        ST_RQ_OUT,
        ST_EMIT_NONE
    } state_t;

    typedef struct packed {
        logic [7:0]  word_char;
        logic [23:0] frequency;
        logic [8:0]  distinct_words;
        logic        entry_valid;
        logic        last_of_run;
        logic        table_full;
        logic        word_cut;
    } result_t;

endpackage

// File: rtl/wft_tables.sv
`timescale 1ns / 1ps

module wft_tables #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_WORD_LEN  = 32,
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int LW = $clog2(MAX_WORD_LEN + 1),
    localparam int SW = $clog2(TABLE_ENTRIES * MAX_WORD_LEN)
) (
    input  logic          clk,
    // character store, two read ports
    input  logic [SW-1:0] st_ra_addr,
    input  logic [SW-1:0] st_rb_addr,
    output logic [7:0]    st_ra_data,
    output logic [7:0]    st_rb_data,
    input  logic          st_we,
    input  logic [SW-1:0] st_waddr,
    input  logic [7:0]    st_wdata,
    // word lengths, two read ports
    input  logic [IW-1:0] ln_ra_addr,
    input  logic [IW-1:0] ln_rb_addr,
    output logic [LW-1:0] ln_ra_data,
    output logic [LW-1:0] ln_rb_data,
    input  logic          ln_we,
    input  logic [IW-1:0] ln_waddr,
    input  logic [LW-1:0] ln_wdata,
    // counts, two read ports
    output logic [23:0]   fq_ra_data,
    output logic [23:0]   fq_rb_data,
    input  logic          fq_we,
    input  logic [IW-1:0] fq_waddr,
    input  logic [23:0]   fq_wdata,
    // rank order, one read port
    input  logic [IW-1:0] rk_raddr,
    output logic [IW-1:0] rk_rdata,
    input  logic          rk_we,
    input  logic [IW-1:0] rk_waddr,
    input  logic [IW-1:0] rk_wdata
);

    logic [7:0]    store_mem [TABLE_ENTRIES*MAX_WORD_LEN];
    logic [LW-1:0] len_mem   [TABLE_ENTRIES];
    logic [23:0]   freq_mem  [TABLE_ENTRIES];
    logic [IW-1:0] rank_mem  [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        st_ra_data <= store_mem[st_ra_addr];
        st_rb_data <= store_mem[st_rb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ln_we)
        begin
            len_mem[ln_waddr] <= ln_wdata;
        end
        ln_ra_data <= len_mem[ln_ra_addr];
        ln_rb_data <= len_mem[ln_rb_addr];
    end

    // counts share the length read addresses
    always_ff @(posedge clk)
    begin
        if (fq_we)
        begin
            freq_mem[fq_waddr] <= fq_wdata;
        end
        fq_ra_data <= freq_mem[ln_ra_addr];
        fq_rb_data <= freq_mem[ln_rb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rank_mem[rk_waddr] <= rk_wdata;
        end
        rk_rdata <= rank_mem[rk_raddr];
    end

endmodule

// File: rtl/wft_out.sv
`timescale 1ns / 1ps

module wft_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  wft_pkg::result_t push_data,
    output logic             out_valid,
    input  logic             out_ready,
    output wft_pkg::result_t out_data
);

    logic             valid_reg;
    wft_pkg::result_t data_reg;

    assign push_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push_ready)
        begin
            valid_reg <= push_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ready && push_valid)
        begin
            data_reg <= push_data;
        end
    end

endmodule

// File: rtl/wft_ctrl.sv
`timescale 1ns / 1ps

module wft_ctrl #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_WORD_LEN  = 32,
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int CW = $clog2(TABLE_ENTRIES + 1),
    localparam int LW = $clog2(MAX_WORD_LEN + 1),
    localparam int PW = $clog2(MAX_WORD_LEN),
    localparam int SW = $clog2(TABLE_ENTRIES * MAX_WORD_LEN)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_action,
    input  logic [7:0]       in_byte,
    input  logic [7:0]       in_rank,
    output logic             push_valid,
    input  logic             push_ready,
    output wft_pkg::result_t push_data,
    output logic [SW-1:0]    st_ra_addr,
    output logic [SW-1:0]    st_rb_addr,
    input  logic [7:0]       st_ra_data,
    input  logic [7:0]       st_rb_data,
    output logic             st_we,
    output logic [SW-1:0]    st_waddr,
    output logic [7:0]       st_wdata,
    output logic [IW-1:0]    ln_ra_addr,
    output logic [IW-1:0]    ln_rb_addr,
    input  logic [LW-1:0]    ln_ra_data,
    input  logic [LW-1:0]    ln_rb_data,
    output logic             ln_we,
    output logic [IW-1:0]    ln_waddr,
    output logic [LW-1:0]    ln_wdata,
    input  logic [23:0]      fq_ra_data,
    input  logic [23:0]      fq_rb_data,
    output logic             fq_we,
    output logic [IW-1:0]    fq_waddr,
    output logic [23:0]      fq_wdata,
    output logic [IW-1:0]    rk_raddr,
    input  logic [IW-1:0]    rk_rdata,
    output logic             rk_we,
    output logic [IW-1:0]    rk_waddr,
    output logic [IW-1:0]    rk_wdata
);

    wft_pkg::state_t state_reg, state_next;
    logic [CW-1:0] e_reg, e_next;
    logic [IW-1:0] u_reg, u_next;
    logic [PW-1:0] k_reg, k_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [IW-1:0] raddr_reg, raddr_next;
    logic [LW-1:0] plen_reg, plen_next;
    logic [CW-1:0] total_reg, total_next;
    logic          after_reg, after_next;
    logic          full_reg, full_next;
    logic          cut_reg, cut_next;

    // pending word buffer
    logic [7:0]    pend_mem [MAX_WORD_LEN];
    logic [7:0]    pend_q;
    logic          pend_we;
    logic [7:0]    lc_byte;
    logic          is_delim;
    logic          is_letter;
    logic          cmp_done;
    logic          cmp_before;
    logic          k_last_pend;
    logic          k_last_a;

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[plen_reg[PW-1:0]] <= lc_byte;
        end
        pend_q <= pend_mem[k_reg];
    end

    assign lc_byte = (in_byte >= wft_pkg::CH_UP_A && in_byte <= wft_pkg::CH_UP_Z) ?
                     in_byte + wft_pkg::CASE_OFS : in_byte;
    assign is_letter = lc_byte >= wft_pkg::CH_LO_A && lc_byte <= wft_pkg::CH_LO_Z;
    assign is_delim  = in_byte == wft_pkg::CH_SPACE || in_byte == wft_pkg::CH_TAB ||
                       in_byte == wft_pkg::CH_LF || in_byte == wft_pkg::CH_CR;

    assign k_last_pend = (32'(k_reg) + 1) == 32'(plen_reg);
    assign k_last_a    = (32'(k_reg) + 1) == 32'(ln_ra_data);

    // entry a is the searched or inserted entry, entry b the sort neighbor
    assign st_ra_addr = SW'(SW'(e_reg[IW-1:0]) * SW'(MAX_WORD_LEN)) + SW'(k_reg);
    assign st_rb_addr = SW'(SW'(u_reg) * SW'(MAX_WORD_LEN)) + SW'(k_reg);
    assign st_waddr   = st_ra_addr;
    assign st_wdata   = pend_q;
    assign ln_ra_addr = e_reg[IW-1:0];
    assign ln_rb_addr = u_reg;
    assign ln_waddr   = e_reg[IW-1:0];
    assign ln_wdata   = plen_reg;
    assign fq_waddr   = e_reg[IW-1:0];
    assign rk_raddr   = raddr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wft_pkg::ST_IDLE;
            e_reg     <= '0;
            u_reg     <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            raddr_reg <= '0;
            plen_reg  <= '0;
            total_reg <= '0;
            after_reg <= 1'b0;
            full_reg  <= 1'b0;
            cut_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            e_reg     <= e_next;
            u_reg     <= u_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            raddr_reg <= raddr_next;
            plen_reg  <= plen_next;
            total_reg <= total_next;
            after_reg <= after_next;
            full_reg  <= full_next;
            cut_reg   <= cut_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        e_next     = e_reg;
        u_next     = u_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        raddr_next = raddr_reg;
        plen_next  = plen_reg;
        total_next = total_reg;
        after_next = after_reg;
        full_next  = full_reg;
        cut_next   = cut_reg;
        in_ready   = 1'b0;
        pend_we    = 1'b0;
        st_we      = 1'b0;
        ln_we      = 1'b0;
        fq_we      = 1'b0;
        fq_wdata   = 24'd1;
        rk_we      = 1'b0;
        rk_waddr   = e_reg[IW-1:0];
        rk_wdata   = e_reg[IW-1:0];
        cmp_done   = 1'b0;
        cmp_before = 1'b0;
        push_valid = 1'b0;
        push_data.word_char      = 8'd0;
        push_data.frequency      = 24'd0;
        push_data.distinct_words = 9'(total_reg);
        push_data.entry_valid    = 1'b0;
        push_data.last_of_run    = 1'b1;
        push_data.table_full     = full_reg;
        push_data.word_cut       = cut_reg;

        unique case (state_reg)
            wft_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (wft_pkg::action_t'(in_action))
                        wft_pkg::ACT_TEXT:
                        begin
                            if (is_delim)
                            begin
                                if (plen_reg != '0)
                                begin
                                    e_next     = '0;
                                    after_next = 1'b0;
                                    state_next = wft_pkg::ST_FL_E;
                                end
                            end
                            else if (is_letter)
                            begin
                                if (32'(plen_reg) < MAX_WORD_LEN)
                                begin
                                    pend_we   = 1'b1;
                                    plen_next = plen_reg + 1'b1;
                                end
                                else
                                begin
                                    cut_next = 1'b1;
                                end
                            end
                        end
                        wft_pkg::ACT_SORT:
                        begin
                            after_next = 1'b1;
                            e_next     = '0;
                            i_next     = '0;
                            state_next = (plen_reg != '0) ? wft_pkg::ST_FL_E :
                                                            wft_pkg::ST_INIT;
                        end
                        wft_pkg::ACT_READ:
                        begin
                            if (32'(in_rank) >= 32'(total_reg))
                            begin
                                state_next = wft_pkg::ST_EMIT_NONE;
                            end
                            else
                            begin
                                raddr_next = IW'(in_rank);
                                state_next = wft_pkg::ST_RQ_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // word lookup: one entry per pass, length first
            wft_pkg::ST_FL_E:
            begin
                if (e_reg == total_reg)
                begin
                    if (32'(total_reg) >= TABLE_ENTRIES)
                    begin
                        full_next  = 1'b1;
                        state_next = wft_pkg::ST_FL_DONE;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = wft_pkg::ST_CP_W;
                    end
                end
                else
                begin
                    state_next = wft_pkg::ST_FL_L;
                end
            end
            wft_pkg::ST_FL_L:
            begin
                if (ln_ra_data == plen_reg)
                begin
                    k_next     = '0;
                    state_next = wft_pkg::ST_FL_CW;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = wft_pkg::ST_FL_E;
                end
            end
            wft_pkg::ST_FL_CW:
            begin
                state_next = wft_pkg::ST_FL_C;
            end
            wft_pkg::ST_FL_C:
            begin
                if (st_ra_data != pend_q)
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = wft_pkg::ST_FL_E;
                end
                else if (k_last_pend)
                begin
                    fq_we      = fq_ra_data != wft_pkg::FREQ_MAX;
                    fq_wdata   = fq_ra_data + 24'd1;
                    state_next = wft_pkg::ST_FL_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = wft_pkg::ST_FL_CW;
                end
            end
            // new entry: copy the pending word in, one letter a pass
            wft_pkg::ST_CP_W:
            begin
                state_next = wft_pkg::ST_CP;
            end
            wft_pkg::ST_CP:
            begin
                st_we = 1'b1;
                if (k_last_pend)
                begin
                    ln_we      = 1'b1;
                    fq_we      = 1'b1;
                    rk_we      = 1'b1;
                    total_next = total_reg + 1'b1;
                    state_next = wft_pkg::ST_FL_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = wft_pkg::ST_CP_W;
                end
            end
            wft_pkg::ST_FL_DONE:
            begin
                plen_next = '0;
                i_next    = '0;
                state_next = after_reg ? wft_pkg::ST_INIT : wft_pkg::ST_IDLE;
            end
            // sort: identity order, then insertion sort
            wft_pkg::ST_INIT:
            begin
                if (i_reg == total_reg)
                begin
                    i_next     = CW'(1);
                    state_next = wft_pkg::ST_SI;
                end
                else
                begin
                    rk_we    = 1'b1;
                    rk_waddr = i_reg[IW-1:0];
                    rk_wdata = i_reg[IW-1:0];
                    i_next   = i_reg + 1'b1;
                end
            end
            wft_pkg::ST_SI:
            begin
                if (i_reg >= total_reg)
                begin
                    state_next = wft_pkg::ST_EMIT_NONE;
                end
                else
                begin
                    raddr_next = i_reg[IW-1:0];
                    state_next = wft_pkg::ST_SI_RD;
                end
            end
            wft_pkg::ST_SI_RD:
            begin
                state_next = wft_pkg::ST_SI_GET;
            end
            wft_pkg::ST_SI_GET:
            begin
                e_next     = CW'(rk_rdata);
                j_next     = i_reg;
                state_next = wft_pkg::ST_SJ;
            end
            wft_pkg::ST_SJ:
            begin
                if (j_reg == '0)
                begin
                    rk_we      = 1'b1;
                    rk_waddr   = '0;
                    i_next     = i_reg + 1'b1;
                    state_next = wft_pkg::ST_SI;
                end
                else
                begin
                    raddr_next = IW'(j_reg - 1'b1);
                    state_next = wft_pkg::ST_SJ_RD;
                end
            end
            wft_pkg::ST_SJ_RD:
            begin
                state_next = wft_pkg::ST_SJ_GET;
            end
            wft_pkg::ST_SJ_GET:
            begin
                u_next     = rk_rdata;
                k_next     = '0;
                state_next = wft_pkg::ST_CMP_RD;
            end
            wft_pkg::ST_CMP_RD:
            begin
                state_next = wft_pkg::ST_CMP_F;
            end
            wft_pkg::ST_CMP_F:
            begin
                if (fq_ra_data != fq_rb_data)
                begin
                    cmp_done   = 1'b1;
                    cmp_before = fq_ra_data > fq_rb_data;
                end
                else if (ln_ra_data != ln_rb_data)
                begin
                    cmp_done   = 1'b1;
                    cmp_before = ln_ra_data > ln_rb_data;
                end
                else
                begin
                    state_next = wft_pkg::ST_CMP_C;
                end
            end
            wft_pkg::ST_CMP_CW:
            begin
                state_next = wft_pkg::ST_CMP_C;
            end
            wft_pkg::ST_CMP_C:
            begin
                if (st_ra_data != st_rb_data)
                begin
                    cmp_done   = 1'b1;
                    cmp_before = st_ra_data < st_rb_data;
                end
                else if (k_last_a)
                begin
                    cmp_done = 1'b1;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = wft_pkg::ST_CMP_CW;
                end
            end
            // ranked read: one character per result
            wft_pkg::ST_RQ_RD:
            begin
                state_next = wft_pkg::ST_RQ_GET;
            end
            wft_pkg::ST_RQ_GET:
            begin
                e_next     = CW'(rk_rdata);
                k_next     = '0;
                state_next = wft_pkg::ST_RQ_W;
            end
            wft_pkg::ST_RQ_W:
            begin
                state_next = wft_pkg::ST_RQ_OUT;
            end
            wft_pkg::ST_RQ_OUT:
            begin
                push_valid            = 1'b1;
                push_data.word_char   = st_ra_data;
                push_data.frequency   = fq_ra_data;
                push_data.entry_valid = 1'b1;
                push_data.last_of_run = k_last_a;
                if (push_ready)
                begin
                    if (k_last_a)
                    begin
                        state_next = wft_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = wft_pkg::ST_RQ_W;
                    end
                end
            end
            wft_pkg::ST_EMIT_NONE:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = wft_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wft_pkg::ST_IDLE;
            end
        endcase

        // insertion step outcome: shift neighbor up or drop the word in place
        if (cmp_done)
        begin
            rk_we    = 1'b1;
            rk_waddr = j_reg[IW-1:0];
            if (cmp_before)
            begin
                rk_wdata   = u_reg;
                j_next     = j_reg - 1'b1;
                state_next = wft_pkg::ST_SJ;
            end
            else
            begin
                i_next     = i_reg + 1'b1;
                state_next = wft_pkg::ST_SI;
            end
        end
    end

endmodule

// File: rtl/word_frequency_table.sv
`timescale 1ns / 1ps

// word frequency counter: text arrives one byte per request; space, tab, lf and
// cr end a token, letters are lowercased and anything else is dropped. at each
// word end the stored words are walked entry by entry in on-chip memory, length
// first and then letter by letter, and a new word is stored one letter at a
// time. an end-of-text request flushes the pending word, runs an insertion sort
// over the table (count desc, length desc, bytes asc), whose number of
// comparisons can grow with the square of the number of distinct words; it
// answers with one marker result. a read request returns the ranked word one
// letter per result, tlast on the last. no clearing pass after reset: the
// memories keep their contents and only the entry count, pending word length,
// flags and sequencer state are reset. full table and long words set sticky
// flags that every result carries.

module word_frequency_table #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_WORD_LEN  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // text_byte[7:0], rank[15:8]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // word_char[7:0], frequency[31:8], distinct_words[40:32], table_full[41],
    // word_cut[42], zero fill[47:43]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser,   // entry_valid
    output logic        m_axis_tlast    // last_of_run
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LW = $clog2(MAX_WORD_LEN + 1);
    localparam int SW = $clog2(TABLE_ENTRIES * MAX_WORD_LEN);

    // memory ports between the sequencer and the tables
    logic [SW-1:0] st_ra_addr, st_rb_addr, st_waddr;
    logic [7:0]    st_ra_data, st_rb_data, st_wdata;
    logic          st_we;
    logic [IW-1:0] ln_ra_addr, ln_rb_addr, ln_waddr;
    logic [LW-1:0] ln_ra_data, ln_rb_data, ln_wdata;
    logic          ln_we;
    logic [23:0]   fq_ra_data, fq_rb_data, fq_wdata;
    logic          fq_we;
    logic [IW-1:0] fq_waddr;
    logic [IW-1:0] rk_raddr, rk_rdata, rk_waddr, rk_wdata;
    logic          rk_we;

    // result path into the output register
    logic             push_valid;
    logic             push_ready;
    wft_pkg::result_t push_data;
    wft_pkg::result_t out_data;

    wft_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_WORD_LEN  (MAX_WORD_LEN)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_action  (s_axis_tuser),
        .in_byte    (s_axis_tdata[7:0]),
        .in_rank    (s_axis_tdata[15:8]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .st_ra_addr (st_ra_addr),
        .st_rb_addr (st_rb_addr),
        .st_ra_data (st_ra_data),
        .st_rb_data (st_rb_data),
        .st_we      (st_we),
        .st_waddr   (st_waddr),
        .st_wdata   (st_wdata),
        .ln_ra_addr (ln_ra_addr),
        .ln_rb_addr (ln_rb_addr),
        .ln_ra_data (ln_ra_data),
        .ln_rb_data (ln_rb_data),
        .ln_we      (ln_we),
        .ln_waddr   (ln_waddr),
        .ln_wdata   (ln_wdata),
        .fq_ra_data (fq_ra_data),
        .fq_rb_data (fq_rb_data),
        .fq_we      (fq_we),
        .fq_waddr   (fq_waddr),
        .fq_wdata   (fq_wdata),
        .rk_raddr   (rk_raddr),
        .rk_rdata   (rk_rdata),
        .rk_we      (rk_we),
        .rk_waddr   (rk_waddr),
        .rk_wdata   (rk_wdata)
    );

    wft_tables #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_WORD_LEN  (MAX_WORD_LEN)
    ) u_tables (
        .clk        (clk),
        .st_ra_addr (st_ra_addr),
        .st_rb_addr (st_rb_addr),
        .st_ra_data (st_ra_data),
        .st_rb_data (st_rb_data),
        .st_we      (st_we),
        .st_waddr   (st_waddr),
        .st_wdata   (st_wdata),
        .ln_ra_addr (ln_ra_addr),
        .ln_rb_addr (ln_rb_addr),
        .ln_ra_data (ln_ra_data),
        .ln_rb_data (ln_rb_data),
        .ln_we      (ln_we),
        .ln_waddr   (ln_waddr),
        .ln_wdata   (ln_wdata),
        .fq_ra_data (fq_ra_data),
        .fq_rb_data (fq_rb_data),
        .fq_we      (fq_we),
        .fq_waddr   (fq_waddr),
        .fq_wdata   (fq_wdata),
        .rk_raddr   (rk_raddr),
        .rk_rdata   (rk_rdata),
        .rk_we      (rk_we),
        .rk_waddr   (rk_waddr),
        .rk_wdata   (rk_wdata)
    );

    // output register keeps a finished result apart from the sequencer
    wft_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (out_data)
    );

    assign m_axis_tdata = {5'd0, out_data.word_cut, out_data.table_full,
                           out_data.distinct_words, out_data.frequency,
                           out_data.word_char};
    assign m_axis_tuser = out_data.entry_valid;
    assign m_axis_tlast = out_data.last_of_run;

endmodule

// File: test/word_frequency_table_test.sv
`timescale 1ns / 1ps

// word frequency table test: text, sort and read requests are pushed into the
// block through the input stream; a local model of the table predicts every
// ranked letter and marker result, and a checker compares them in order
module word_frequency_table_test;

    localparam int ENTRY_MAX = 256;
    localparam int WORD_MAX  = 32;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // text_byte[7:0], rank[15:8]
    logic [1:0]  s_axis_tuser = wft_pkg::ACT_NONE;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // word_char[7:0], frequency[31:8], distinct_words[40:32], table_full[41],
    // word_cut[42], zero fill[47:43]
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;   // entry_valid
    logic        m_axis_tlast;   // last_of_run

    word_frequency_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // local copy of the word table
    logic [7:0]  stored_letters [ENTRY_MAX][WORD_MAX];
    int          stored_len [ENTRY_MAX];
    logic [23:0] stored_count [ENTRY_MAX];
    int          rank_slot [ENTRY_MAX];
    int          entries = 0;
    logic [7:0]  cur_letters [WORD_MAX];
    int          cur_len = 0;
    bit          full_seen = 0;
    bit          cut_seen = 0;

    wft_pkg::result_t letter_queue [$];   // ranked letters and markers still due
    int          errors = 0;
    int          requests_sent = 0;
    int          results_seen = 0;
    int          sorts_sent = 0;
    int          reads_sent = 0;
    int          burst_left = 0;
    bit          hold_request = 0;
    int          hold_left = 0;
    int          stall_mode = 0;
    int          cycle_count = 0;

    function automatic wft_pkg::result_t make_result(logic [7:0] ch, logic [23:0] freq,
                                                     bit valid, bit last);
        wft_pkg::result_t r;
        r.word_char      = ch;
        r.frequency      = freq;
        r.distinct_words = entries[8:0];
        r.entry_valid    = valid;
        r.last_of_run    = last;
        r.table_full     = full_seen;
        r.word_cut       = cut_seen;
        return r;
    endfunction

    // word end: bump a match or append a new entry
    task automatic close_word();
        int n;
        bit same;
        n = cur_len;
        cur_len = 0;
        if (n == 0)
            return;
        for (int e = 0; e < entries; e++)
        begin
            same = (stored_len[e] == n);
            for (int i = 0; i < n && same; i++)
                if (stored_letters[e][i] != cur_letters[i])
                    same = 0;
            if (same)
            begin
                if (stored_count[e] != wft_pkg::FREQ_MAX)
                    stored_count[e]++;
                return;
            end
        end
        if (entries >= ENTRY_MAX)
        begin
            full_seen = 1;
            return;
        end
        for (int i = 0; i < n; i++)
            stored_letters[entries][i] = cur_letters[i];
        stored_len[entries] = n;
        stored_count[entries] = 1;
        rank_slot[entries] = entries;
        entries++;
    endtask

    // count desc, length desc, then bytes asc
    function automatic bit ranks_ahead(int a, int b);
        if (stored_count[a] != stored_count[b])
            return stored_count[a] > stored_count[b];
        if (stored_len[a] != stored_len[b])
            return stored_len[a] > stored_len[b];
        for (int i = 0; i < stored_len[a]; i++)
            if (stored_letters[a][i] != stored_letters[b][i])
                return stored_letters[a][i] < stored_letters[b][i];
        return 0;
    endfunction

    task automatic rank_entries();
        int v;
        int j;
        for (int i = 0; i < entries; i++)
            rank_slot[i] = i;
        for (int i = 1; i < entries; i++)
        begin
            v = rank_slot[i];
            j = i;
            while (j > 0 && ranks_ahead(v, rank_slot[j - 1]))
            begin
                rank_slot[j] = rank_slot[j - 1];
                j--;
            end
            rank_slot[j] = v;
        end
    endtask

    // predict the results of one accepted request
    task automatic count_request(wft_pkg::action_t act, logic [7:0] ch, logic [7:0] rank);
        logic [7:0] c;
        int e;
        c = ch;
        case (act)
            wft_pkg::ACT_TEXT:
                if (c == wft_pkg::CH_SPACE || c == wft_pkg::CH_TAB ||
                    c == wft_pkg::CH_LF || c == wft_pkg::CH_CR)
                    close_word();
                else
                begin
                    if (c >= wft_pkg::CH_UP_A && c <= wft_pkg::CH_UP_Z)
                        c = c + wft_pkg::CASE_OFS;
                    if (c >= wft_pkg::CH_LO_A && c <= wft_pkg::CH_LO_Z)
                    begin
                        if (cur_len < WORD_MAX)
                            cur_letters[cur_len++] = c;
                        else
                            cut_seen = 1;
                    end
                end
            wft_pkg::ACT_SORT:
            begin
                close_word();
                rank_entries();
                letter_queue.push_back(make_result(8'h00, 24'h0, 0, 1));
            end
            wft_pkg::ACT_READ:
                if (rank >= entries)
                    letter_queue.push_back(make_result(8'h00, 24'h0, 0, 1));
                else
                begin
                    e = rank_slot[rank];
                    for (int i = 0; i < stored_len[e]; i++)
                        letter_queue.push_back(make_result(stored_letters[e][i],
                            stored_count[e], 1, i + 1 == stored_len[e]));
                end
            default: ;   // unused action, ignored
        endcase
    endtask

    // one request; the sender runs in bursts with random gaps between them
    task automatic send(wft_pkg::action_t act, logic [7:0] ch, logic [7:0] rank);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rank, ch};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
        if (act == wft_pkg::ACT_SORT)
            sorts_sent++;
        if (act == wft_pkg::ACT_READ)
            reads_sent++;
        count_request(act, ch, rank);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send(wft_pkg::ACT_TEXT, s[i], 8'($urandom_range(0, 255)));
    endtask

    // sender pause until every predicted result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (letter_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // receiver: checks each result and stalls on its own pattern
    always @(posedge clk)
    begin
        wft_pkg::result_t got;
        wft_pkg::result_t want;
        cycle_count++;
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            got.word_char      = m_axis_tdata[7:0];
            got.frequency      = m_axis_tdata[31:8];
            got.distinct_words = m_axis_tdata[40:32];
            got.table_full     = m_axis_tdata[41];
            got.word_cut       = m_axis_tdata[42];
            got.entry_valid    = m_axis_tuser;
            got.last_of_run    = m_axis_tlast;
            if (letter_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         got);
            end
            else
            begin
                want = letter_queue.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: expected char %h freq %0d words %0d v %b l %b f %b c %b",
                             $time, want.word_char, want.frequency, want.distinct_words,
                             want.entry_valid, want.last_of_run, want.table_full,
                             want.word_cut);
                    $display("%0t: actual   char %h freq %0d words %0d v %b l %b f %b c %b",
                             $time, got.word_char, got.frequency, got.distinct_words,
                             got.entry_valid, got.last_of_run, got.table_full,
                             got.word_cut);
                end
            end
        end
        if (hold_request)
        begin
            hold_request <= 0;
            hold_left = 400;
        end
        if (cycle_count % 300 == 0)
            stall_mode = $urandom_range(0, 3);
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 0);
                2: m_axis_tready <= ($urandom_range(0, 4) != 0);
                default: m_axis_tready <= (cycle_count % 7 < 3);
            endcase
    end

    // all four delimiters, case folding, junk bytes, read before sort,
    // missing rank, unused action, long word
    task automatic test_directed();
        send_text("Hello\tWORLD\nhe1lo,\r");
        send(wft_pkg::ACT_TEXT, 8'hFF, 8'hFF);
        send(wft_pkg::ACT_TEXT, 8'h00, 8'h00);
        send(wft_pkg::ACT_READ, 8'h00, 8'd1);     // read before any sort
        send(wft_pkg::ACT_READ, 8'hFF, 8'd255);   // missing rank
        send(wft_pkg::ACT_NONE, 8'h41, 8'd0);
        send_text("hello abcdefghijklmnopqrstuvwxyzabcdefghij");
        send(wft_pkg::ACT_SORT, 8'h00, 8'h00);
        for (int r = 0; r < 5; r++)
            send(wft_pkg::ACT_READ, 8'h00, 8'(r));
        drain();
    endtask

    string vocab [16] = '{"the", "cat", "sat", "upon", "mat", "and", "dog", "ran",
                          "far", "away", "from", "home", "quick", "brown", "foxes",
                          "jumped"};

    task automatic test_random(int count);
        int start;
        int pick;
        string w;
        byte ch;
        logic [7:0] delims [4];
        delims = '{wft_pkg::CH_SPACE, wft_pkg::CH_TAB, wft_pkg::CH_LF, wft_pkg::CH_CR};
        start = requests_sent;
        while (requests_sent - start < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                w = vocab[$urandom_range(0, 15)];
                for (int i = 0; i < w.len(); i++)
                begin
                    ch = w[i];
                    if ($urandom_range(0, 3) == 0)
                        ch = ch - 8'h20;
                    send(wft_pkg::ACT_TEXT, ch, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 19) == 0)
                        send(wft_pkg::ACT_TEXT, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                end
                send(wft_pkg::ACT_TEXT, delims[$urandom_range(0, 3)],
                     8'($urandom_range(0, 255)));
            end
            else if (pick < 68)
            begin
                repeat ($urandom_range(33, 38))
                    send(wft_pkg::ACT_TEXT,
                         8'($urandom_range(wft_pkg::CH_LO_A, wft_pkg::CH_LO_Z)), 8'h00);
                send(wft_pkg::ACT_TEXT, wft_pkg::CH_SPACE, 8'h00);
            end
            else if (pick < 76)
                send(wft_pkg::ACT_TEXT, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
            else if (pick < 88)
                send(wft_pkg::ACT_READ, 8'($urandom_range(0, 255)),
                     (entries > 0) ? 8'($urandom_range(0, entries - 1)) : 8'd0);
            else if (pick < 92)
                send(wft_pkg::ACT_SORT, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
            else if (pick < 95)
                send(wft_pkg::ACT_NONE, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
            else
                send(wft_pkg::ACT_READ, 8'h00, 8'($urandom_range(0, 255)));
        end
        drain();
    endtask

    // receiver holds off while reads keep coming, so the input stalls
    task automatic test_backpressure();
        hold_request <= 1;
        @(posedge clk);
        repeat (12)
            send(wft_pkg::ACT_READ, 8'h00,
                 (entries > 0) ? 8'($urandom_range(0, entries - 1)) : 8'd0);
        drain();
    endtask

    // distinct two-letter words until the table overflows, then extreme ranks
    task automatic test_full_table();
        int extra;
        int k;
        extra = 0;
        k = 0;
        while (extra < 4 && k < 676)
        begin
            if (entries == ENTRY_MAX)
                extra++;
            send(wft_pkg::ACT_TEXT, wft_pkg::CH_LO_A + 8'(k / 26), 8'h00);
            send(wft_pkg::ACT_TEXT, wft_pkg::CH_LO_A + 8'(k % 26), 8'h00);
            send(wft_pkg::ACT_TEXT, wft_pkg::CH_SPACE, 8'h00);
            k++;
        end
        send(wft_pkg::ACT_READ, 8'h00, 8'd255);
        send(wft_pkg::ACT_SORT, 8'h00, 8'h00);
        send(wft_pkg::ACT_READ, 8'h00, 8'd0);
        send(wft_pkg::ACT_READ, 8'h00, 8'd255);
        send(wft_pkg::ACT_READ, 8'h00, 8'd128);
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(410);
        test_backpressure();
        test_full_table();
        repeat (200) @(posedge clk);
        $display("sent %0d requests (%0d sorts, %0d reads), checked %0d results",
                 requests_sent, sorts_sent, reads_sent, results_seen);
        $display("covered delimiters, long words, missing ranks, stalls and a full table");
        if (errors == 0 && letter_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
